/* rtl/gtht_pkg.sv */
// Shared types, codes and helpers for the generation-tagged handle table.
`default_nettype none

package gtht_pkg;

    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 3;
    localparam int GEN_W    = HANDLE_W - SLOT_W;
    localparam int ENTRY_W  = 12;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_MOUNT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_MOUNTED = 2'd1,
        STATUS_NO_SLOT     = 2'd2,
        STATUS_BAD_HANDLE  = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                  command;
        logic                  unmount_flag;
        logic [HANDLE_W-1:0]   handle_in;
        logic [ENTRY_W-1:0]    entry_index;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   handle_out;
        logic [SLOT_W-1:0]     slot_idx;
        logic [ENTRY_W-1:0]    entry_out;
    } t_rsp;

    // Advance a generation, stepping over zero on wrap.
    function automatic logic [GEN_W-1:0] gtht_next_gen(input logic [GEN_W-1:0] gen);
        logic [GEN_W-1:0] nxt;
        nxt = gen + GEN_W'(1);
        if (nxt == '0) begin
            nxt = GEN_W'(1);
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

/* rtl/generation_tagged_handle_table_top.sv */
// Top level of the generation-tagged handle table: slot state, decode and result register.
// Flow: a request is taken into the request register, executed against the table, and
//   its result held in the result register; it shows for one cycle, marked by o_valid.
// Throughput: one request per cycle; busy stays low, since the slot search, handle
//   compare and generation bump all fit between the request and result registers.
// Reset: synchronous, active low; frees every slot, zeroes every generation and
//   leaves the table unmounted. Bound entry indices are not cleared.
`default_nettype none

module generation_tagged_handle_table_top #(
    parameter int NUM_SLOTS  = 8,
    parameter int ENTRY_BITS = 12
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  gtht_pkg::t_req   i_req,
    output logic             o_valid,
    output gtht_pkg::t_rsp   o_rsp
);
    import gtht_pkg::*;

    // Request stage
    logic                   r_req_vld;
    t_req                   r_req;

    // Slot table
    logic [NUM_SLOTS-1:0]   r_busy,    n_busy;
    logic [GEN_W-1:0]       r_gen      [NUM_SLOTS];
    logic [GEN_W-1:0]       n_gen      [NUM_SLOTS];
    logic [ENTRY_BITS-1:0]  r_entry    [NUM_SLOTS];
    logic [ENTRY_BITS-1:0]  n_entry    [NUM_SLOTS];
    logic                   r_mounted, n_mounted;

    // Result stage
    logic                   r_rsp_vld, n_rsp_vld;
    t_rsp                   r_rsp,     n_rsp;

    // Decode helpers
    logic [SLOT_W-1:0]      hslot;
    logic [GEN_W-1:0]       hgen;
    logic [NUM_SLOTS-1:0]   hit;
    logic [NUM_SLOTS-1:0]   first_free;
    logic [ENTRY_BITS-1:0]  hit_entry;
    logic [ENTRY_BITS+ENTRY_W-1:0] entry_in_ext;
    logic [ENTRY_BITS+ENTRY_W-1:0] entry_out_ext;

    // Never stall: every request goes straight into the request register.
    assign busy    = 1'b0;
    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

    assign hslot = r_req.handle_in[SLOT_W-1:0];
    assign hgen  = r_req.handle_in[HANDLE_W-1:SLOT_W];

    // Resize entry indices between the port width and the stored width.
    assign entry_in_ext  = {{ENTRY_BITS{1'b0}}, r_req.entry_index};
    assign entry_out_ext = {{ENTRY_W{1'b0}}, hit_entry};

    // Handle match: slot in range, nonzero matching generation, slot busy, mounted.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            hit[i] = r_mounted && r_busy[i] && (hgen != '0) && (r_gen[i] == hgen)
                     && (hslot == SLOT_W'(i));
        end
    end

    // Lowest free slot as a one-hot vector.
    always_comb begin
        logic found;
        found      = 1'b0;
        first_free = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!r_busy[i] && !found) begin
                first_free[i] = 1'b1;
                found         = 1'b1;
            end
        end
    end

    // Select the bound entry of the matching slot; at most one slot can hit.
    always_comb begin
        hit_entry = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (hit[i]) begin
                hit_entry = hit_entry | r_entry[i];
            end
        end
    end

    // Execute the held request against the table and form the result.
    always_comb begin
        n_busy    = r_busy;
        n_gen     = r_gen;
        n_entry   = r_entry;
        n_mounted = r_mounted;
        n_rsp_vld = r_req_vld;
        n_rsp     = '0;
        n_rsp.status = STATUS_OK;

        if (r_req_vld) begin
            unique case (r_req.command)
                CMD_OPEN: begin
                    if (!r_mounted) begin
                        n_rsp.status = STATUS_NOT_MOUNTED;
                    end else if (first_free == '0) begin
                        n_rsp.status = STATUS_NO_SLOT;
                    end else begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (first_free[i]) begin
                                n_gen[i]         = gtht_next_gen(r_gen[i]);
                                n_busy[i]        = 1'b1;
                                n_entry[i]       = entry_in_ext[ENTRY_BITS-1:0];
                                n_rsp.handle_out = {gtht_next_gen(r_gen[i]), SLOT_W'(i)};
                            end
                        end
                    end
                end
                CMD_CLOSE, CMD_CHECK: begin
                    if (hit != '0) begin
                        n_rsp.slot_idx  = hslot;
                        n_rsp.entry_out = entry_out_ext[ENTRY_W-1:0];
                        if (r_req.command == CMD_CLOSE) begin
                            n_busy = r_busy & ~hit;
                        end
                    end else begin
                        n_rsp.status = STATUS_BAD_HANDLE;
                    end
                end
                CMD_MOUNT: begin
                    // Mount bumps all generations; unmount keeps them.
                    n_busy = '0;
                    if (!r_req.unmount_flag) begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            n_gen[i] = gtht_next_gen(r_gen[i]);
                        end
                    end
                    n_mounted = !r_req.unmount_flag;
                end
                default: begin
                    n_rsp.status = STATUS_OK;
                end
            endcase
        end
    end

    // Control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            r_busy    <= '0;
            r_mounted <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_gen[i] <= '0;
            end
        end else begin
            r_req_vld <= start && !busy;
            r_rsp_vld <= n_rsp_vld;
            r_busy    <= n_busy;
            r_mounted <= n_mounted;
            r_gen     <= n_gen;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_rsp   <= n_rsp;
        r_entry <= n_entry;
    end

    // Every accepted request yields exactly one result, through the request and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted request produced no result");

    // An unmounted table never holds an open slot.
    a_unmounted_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mounted |-> (r_busy == '0))
        else $error("slot busy while table unmounted");

    // A handed-out handle always carries a nonzero generation and an OK status.
    a_handle_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.handle_out != '0)) |->
        ((o_rsp.handle_out[HANDLE_W-1:SLOT_W] != '0) && (o_rsp.status == STATUS_OK)))
        else $error("handle issued with zero generation or error status");

    // A rejected request reports no slot, entry or handle.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != STATUS_OK)) |->
        ((o_rsp.slot_idx == '0) && (o_rsp.entry_out == '0) && (o_rsp.handle_out == '0)))
        else $error("error result carries payload");

endmodule

`default_nettype wire
